>>> src/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// shared types, constants and calendar functions for the days-between unit
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int DOY_W    = 9;
   localparam int DAYS_W   = 18;

   localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1600);
   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(2100);
   // first year past the valid span, exclusive end of the year sweep
   localparam logic [YEAR_W-1:0] YEAR_END = YEAR_W'(2101);

   localparam logic [DOY_W-1:0] DAYS_COMMON = DOY_W'(365);
   localparam logic [DOY_W-1:0] DAYS_LEAP   = DOY_W'(366);

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture a new transaction
      logic step;     // add one year length and advance the year
      logic finish;   // form the result and load the output registers
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic span_done;  // year sweep reached its end
   } status_type;

   // leap rule, valid for years 1600..2100 only
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic century;
      begin
         century = (y == YEAR_W'(1700)) || (y == YEAR_W'(1800)) ||
                   (y == YEAR_W'(1900)) || (y == YEAR_W'(2100));
         is_leap = (y[1:0] == 2'b00) && !century;
      end
   endfunction

   // month length, month must be 1..12
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      begin
         case (m)
            4'd2:                   month_days = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: month_days = DAY_W'(30);
            default:                month_days = DAY_W'(31);
         endcase
      end
   endfunction

   // days in a common year before the first of the month
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      begin
         case (m)
            4'd2:    days_before = DOY_W'(31);
            4'd3:    days_before = DOY_W'(59);
            4'd4:    days_before = DOY_W'(90);
            4'd5:    days_before = DOY_W'(120);
            4'd6:    days_before = DOY_W'(151);
            4'd7:    days_before = DOY_W'(181);
            4'd8:    days_before = DOY_W'(212);
            4'd9:    days_before = DOY_W'(243);
            4'd10:   days_before = DOY_W'(273);
            4'd11:   days_before = DOY_W'(304);
            4'd12:   days_before = DOY_W'(334);
            default: days_before = DOY_W'(0);
         endcase
      end
   endfunction

   // day number in the year, zero for an invalid date
   function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0]   d,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0]  y);
      logic leap;
      logic ok;
      logic [DOY_W-1:0] total;
      begin
         leap = is_leap(y);
         ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) &&
              (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
              (d != '0) && (d <= month_days(m, leap));
         total = days_before(m) + DOY_W'(d) + DOY_W'(leap && (m > MONTH_FEB));
         day_of_year = ok ? total : '0;
      end
   endfunction

endpackage

>>> src/date_difference_days_unit.sv
// ----------------------------------------------------------------------------
// date_difference_days_unit
// number of days between two gregorian dates, years 1600..2100
// ----------------------------------------------------------------------------
// usage:
//   drive req_day_a .. req_year_b and raise start; the transaction is taken
//   at a clock edge with start high and busy low. busy stays high while the
//   year sweep runs. the result appears on rsp_days_between and
//   rsp_date_invalid for exactly one cycle with rsp_valid high, and the
//   receiver must take it then (no back-pressure).
// timing:
//   one year length is added per cycle over the years from the earlier year
//   up to, but not including, the later one, clamped to 1600..2100. the
//   finish state then registers the result together with the strobe, and
//   busy is already low when the strobe is shown, so a new transaction may
//   be accepted at the edge where the strobe is taken.
// reset:
//   synchronous reset returns the sequencer to idle and drops any
//   transaction in progress; no strobe is produced for it.
// ----------------------------------------------------------------------------
module date_difference_days_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ddd_pkg::DAY_W-1:0]     req_day_a,
   input  logic [ddd_pkg::MONTH_W-1:0]   req_month_a,
   input  logic [ddd_pkg::YEAR_W-1:0]    req_year_a,
   input  logic [ddd_pkg::DAY_W-1:0]     req_day_b,
   input  logic [ddd_pkg::MONTH_W-1:0]   req_month_b,
   input  logic [ddd_pkg::YEAR_W-1:0]    req_year_b,
   output logic                          rsp_valid,
   output logic [ddd_pkg::DAYS_W-1:0]    rsp_days_between,
   output logic                          rsp_date_invalid
);

   ddd_pkg::cmd_type    cmd;
   ddd_pkg::status_type status;

   // sequencer
   ddd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic
   ddd_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_day_a        (req_day_a),
      .req_month_a      (req_month_a),
      .req_year_a       (req_year_a),
      .req_day_b        (req_day_b),
      .req_month_b      (req_month_b),
      .req_year_b       (req_year_b),
      .rsp_days_between (rsp_days_between),
      .rsp_date_invalid (rsp_date_invalid)
   );

   // a result strobe is only shown once the unit is free again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // one strobe per transaction, never two in a row
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // an accepted transaction makes the unit busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("transaction accepted but unit not busy");

   // leaving busy outside reset always delivers a result
   assert property (@(posedge clock) disable iff (reset)
                    ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("transaction ended without a result");

endmodule

>>> src/ddd_ctrl.sv
// ----------------------------------------------------------------------------
// ddd_ctrl
// sequencer: load, year sweep, finish, result strobe
// ----------------------------------------------------------------------------
module ddd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output ddd_pkg::cmd_type    cmd,
   input  ddd_pkg::status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SUM    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.span_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/ddd_datapath.sv
// ----------------------------------------------------------------------------
// ddd_datapath
// day numbers, year-length accumulator and result registers
// ----------------------------------------------------------------------------
module ddd_datapath (
   input  logic                              clock,
   input  ddd_pkg::cmd_type                  cmd,
   output ddd_pkg::status_type               status,
   input  logic [ddd_pkg::DAY_W-1:0]         req_day_a,
   input  logic [ddd_pkg::MONTH_W-1:0]       req_month_a,
   input  logic [ddd_pkg::YEAR_W-1:0]        req_year_a,
   input  logic [ddd_pkg::DAY_W-1:0]         req_day_b,
   input  logic [ddd_pkg::MONTH_W-1:0]       req_month_b,
   input  logic [ddd_pkg::YEAR_W-1:0]        req_year_b,
   output logic [ddd_pkg::DAYS_W-1:0]        rsp_days_between,
   output logic                              rsp_date_invalid
);

   logic [ddd_pkg::DOY_W-1:0]  na_ff, nb_ff;
   logic                       same_year_ff;
   logic                       a_first_ff;
   logic [ddd_pkg::YEAR_W-1:0] year_ff;
   logic [ddd_pkg::YEAR_W-1:0] end_ff;
   logic [ddd_pkg::DAYS_W-1:0] acc_ff;
   logic [ddd_pkg::DAYS_W-1:0] days_ff;
   logic                       invalid_ff;

   logic [ddd_pkg::DOY_W-1:0]  na_in, nb_in;
   logic                       a_first_in;
   logic [ddd_pkg::YEAR_W-1:0] lo_year, hi_year;
   logic [ddd_pkg::YEAR_W-1:0] start_in, end_in;
   logic [ddd_pkg::DOY_W-1:0]  year_len;
   logic [ddd_pkg::DOY_W-1:0]  n_hi, n_lo;
   logic [ddd_pkg::DAYS_W-1:0] days_in;

   // day numbers and clamped year sweep bounds for a new transaction
   always_comb begin
      na_in      = ddd_pkg::day_of_year(req_day_a, req_month_a, req_year_a);
      nb_in      = ddd_pkg::day_of_year(req_day_b, req_month_b, req_year_b);
      a_first_in = (req_year_a < req_year_b);
      lo_year    = a_first_in ? req_year_a : req_year_b;
      hi_year    = a_first_in ? req_year_b : req_year_a;
      start_in   = (lo_year < ddd_pkg::YEAR_MIN) ? ddd_pkg::YEAR_MIN : lo_year;
      end_in     = (hi_year > ddd_pkg::YEAR_MAX) ? ddd_pkg::YEAR_END : hi_year;
   end

   // length of the current sweep year, inside the valid span whenever a step adds it
   assign year_len = ddd_pkg::is_leap(year_ff) ? ddd_pkg::DAYS_LEAP : ddd_pkg::DAYS_COMMON;
   assign status.span_done = (year_ff >= end_ff);

   // final combination, wraps at the result width
   always_comb begin
      n_hi = a_first_ff ? nb_ff : na_ff;
      n_lo = a_first_ff ? na_ff : nb_ff;
      if (same_year_ff) begin
         days_in = (na_ff >= nb_ff) ? ddd_pkg::DAYS_W'(na_ff - nb_ff)
                                    : ddd_pkg::DAYS_W'(nb_ff - na_ff);
      end else begin
         days_in = acc_ff + ddd_pkg::DAYS_W'(n_hi) - ddd_pkg::DAYS_W'(n_lo);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         same_year_ff <= (req_year_a == req_year_b);
         a_first_ff   <= a_first_in;
         year_ff      <= start_in;
         end_ff       <= end_in;
         acc_ff       <= '0;
      end else if (cmd.step) begin
         year_ff <= year_ff + ddd_pkg::YEAR_W'(1);
         acc_ff  <= acc_ff + ddd_pkg::DAYS_W'(year_len);
      end
      if (cmd.finish) begin
         days_ff    <= days_in;
         invalid_ff <= (na_ff == '0) || (nb_ff == '0);
      end
   end

   assign rsp_days_between = days_ff;
   assign rsp_date_invalid = invalid_ff;

endmodule
